// ===== rtl/itr_pkg.sv =====
// ----------------------------------------------------------------------------
// itr_pkg
// Shared constants and types for the target reacquire core: register map,
// pad defaults, outcome codes and the control structs between front and back.
// ----------------------------------------------------------------------------
package itr_pkg;

    localparam int PAD_BITS      = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int MISS_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_PAD_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAD_Y = 2'd1;

    localparam logic [PAD_BITS-1:0] PAD_X_RESET = 10'd150;
    localparam logic [PAD_BITS-1:0] PAD_Y_RESET = 10'd100;

    localparam logic [MISS_BITS-1:0] MISS_MAX = 16'hFFFF;

    localparam logic [1:0] OUT_ID_MATCH = 2'd0;
    localparam logic [1:0] OUT_IOU      = 2'd1;
    localparam logic [1:0] OUT_FALLBACK = 2'd2;
    localparam logic [1:0] OUT_NONE     = 2'd3;

    typedef struct packed {
        logic [PAD_BITS-1:0] pad_x;
        logic [PAD_BITS-1:0] pad_y;
    } t_pads;

    // Classification attached to every queued transaction
    typedef struct packed {
        logic cmd;    // empty-frame marker
        logic last;   // final detection of the frame
        logic first;  // first detection of the frame
    } t_item_ctl;

endpackage

// ===== rtl/iou_target_reacquire_core.sv =====
// ----------------------------------------------------------------------------
// iou_target_reacquire_core
// Per-frame target reacquisition: ID match first, else best padded IoU above
// one tenth against the last known box, else the frame's first box.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid/o_in_ready   | command, det_id, box, last
//   out     | out       | o_out_valid/i_out_ready | outcome, target, id, miss
//
// Once a track exists, each detection runs the overlap test: five products
// go through one shared multiplier, the two cross products split into
// halves. A frame end or empty-frame marker then loads the result register.
// Reset is synchronous, active low; pads return to 150 and 100.
// A two-entry queue parts input from processing; the result register waits
// on i_out_ready while the queue keeps filling.
// ----------------------------------------------------------------------------
module iou_target_reacquire_core
    import itr_pkg::*;
#(
    parameter int PIXEL_BITS = 12,
    parameter int ID_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [ID_BITS-1:0]       i_det_id,
    input  logic [PIXEL_BITS-1:0]    i_box_cx,
    input  logic [PIXEL_BITS-1:0]    i_box_cy,
    input  logic [PIXEL_BITS-1:0]    i_box_w,
    input  logic [PIXEL_BITS-1:0]    i_box_h,
    input  logic                     i_last_in_frame,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_outcome,
    output logic [PIXEL_BITS-1:0]    o_target_x,
    output logic [PIXEL_BITS-1:0]    o_target_y,
    output logic [PIXEL_BITS-1:0]    o_target_h,
    output logic [ID_BITS-1:0]       o_tracked_id,
    output logic [MISS_BITS-1:0]     o_miss_frames,
    output logic                     o_target_present
);

    localparam int SW_BITS = ((PIXEL_BITS > PAD_BITS) ? PIXEL_BITS : PAD_BITS) + 1;

    t_pads                 w_pads;
    logic                  w_q_valid;
    logic                  w_q_pop;
    t_item_ctl             w_q_ctl;
    logic [ID_BITS-1:0]    w_q_id;
    logic [PIXEL_BITS-1:0] w_q_cx;
    logic [PIXEL_BITS-1:0] w_q_cy;
    logic [PIXEL_BITS-1:0] w_q_w;
    logic [PIXEL_BITS-1:0] w_q_h;
    logic [SW_BITS-1:0]    w_q_sw;
    logic [SW_BITS-1:0]    w_q_sh;

    itr_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .ID_BITS    (ID_BITS),
        .SW_BITS    (SW_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pads          (w_pads),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_det_id        (i_det_id),
        .i_box_cx        (i_box_cx),
        .i_box_cy        (i_box_cy),
        .i_box_w         (i_box_w),
        .i_box_h         (i_box_h),
        .i_last_in_frame (i_last_in_frame),
        .o_q_valid       (w_q_valid),
        .i_q_pop         (w_q_pop),
        .o_q_ctl         (w_q_ctl),
        .o_q_id          (w_q_id),
        .o_q_cx          (w_q_cx),
        .o_q_cy          (w_q_cy),
        .o_q_w           (w_q_w),
        .o_q_h           (w_q_h),
        .o_q_sw          (w_q_sw),
        .o_q_sh          (w_q_sh)
    );

    itr_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .ID_BITS    (ID_BITS),
        .SW_BITS    (SW_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_pads               (w_pads),
        .i_q_valid            (w_q_valid),
        .o_q_pop              (w_q_pop),
        .i_q_ctl              (w_q_ctl),
        .i_q_id               (w_q_id),
        .i_q_cx               (w_q_cx),
        .i_q_cy               (w_q_cy),
        .i_q_w                (w_q_w),
        .i_q_h                (w_q_h),
        .i_q_sw               (w_q_sw),
        .i_q_sh               (w_q_sh),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_out_outcome        (o_outcome),
        .o_out_target_x       (o_target_x),
        .o_out_target_y       (o_target_y),
        .o_out_target_h       (o_target_h),
        .o_out_tracked_id     (o_tracked_id),
        .o_out_miss_frames    (o_miss_frames),
        .o_out_target_present (o_target_present)
    );

endmodule

// ===== rtl/itr_front.sv =====
// ----------------------------------------------------------------------------
// itr_front
// Accepts detection transactions, classifies them within the frame, pads the
// box size with the current pad registers and queues them for the back end.
// Also holds the pad configuration registers.
// ----------------------------------------------------------------------------
module itr_front
    import itr_pkg::*;
#(
    parameter int PIXEL_BITS = 12,
    parameter int ID_BITS    = 16,
    parameter int SW_BITS    = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_pads                    o_pads,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [ID_BITS-1:0]       i_det_id,
    input  logic [PIXEL_BITS-1:0]    i_box_cx,
    input  logic [PIXEL_BITS-1:0]    i_box_cy,
    input  logic [PIXEL_BITS-1:0]    i_box_w,
    input  logic [PIXEL_BITS-1:0]    i_box_h,
    input  logic                     i_last_in_frame,
    output logic                     o_q_valid,
    input  logic                     i_q_pop,
    output t_item_ctl                o_q_ctl,
    output logic [ID_BITS-1:0]       o_q_id,
    output logic [PIXEL_BITS-1:0]    o_q_cx,
    output logic [PIXEL_BITS-1:0]    o_q_cy,
    output logic [PIXEL_BITS-1:0]    o_q_w,
    output logic [PIXEL_BITS-1:0]    o_q_h,
    output logic [SW_BITS-1:0]       o_q_sw,
    output logic [SW_BITS-1:0]       o_q_sh
);

    localparam int QDEPTH = 2;
    localparam int QPTR   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT   = $clog2(QDEPTH + 1);

    typedef struct packed {
        t_item_ctl             ctl;
        logic [ID_BITS-1:0]    id;
        logic [PIXEL_BITS-1:0] cx;
        logic [PIXEL_BITS-1:0] cy;
        logic [PIXEL_BITS-1:0] w;
        logic [PIXEL_BITS-1:0] h;
        logic [SW_BITS-1:0]    sw;
        logic [SW_BITS-1:0]    sh;
    } t_entry;

    t_pads            r_pads;
    t_entry           r_q [QDEPTH];
    logic [QPTR-1:0]  r_wptr;
    logic [QPTR-1:0]  r_rptr;
    logic [QCNT-1:0]  r_count;
    logic             r_open;
    t_entry           w_entry;
    t_entry           w_head;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_pads      = r_pads;
    assign o_in_ready  = (r_count != QCNT'(QDEPTH));
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        w_entry.ctl.cmd   = i_command;
        w_entry.ctl.last  = i_last_in_frame;
        w_entry.ctl.first = !r_open;
        w_entry.id        = i_det_id;
        w_entry.cx        = i_box_cx;
        w_entry.cy        = i_box_cy;
        w_entry.w         = i_box_w;
        w_entry.h         = i_box_h;
        w_entry.sw        = SW_BITS'(i_box_w) + SW_BITS'(r_pads.pad_x);
        w_entry.sh        = SW_BITS'(i_box_h) + SW_BITS'(r_pads.pad_y);
    end

    assign w_head    = r_q[r_rptr];
    assign o_q_valid = (r_count != '0);
    assign o_q_ctl   = w_head.ctl;
    assign o_q_id    = w_head.id;
    assign o_q_cx    = w_head.cx;
    assign o_q_cy    = w_head.cy;
    assign o_q_w     = w_head.w;
    assign o_q_h     = w_head.h;
    assign o_q_sw    = w_head.sw;
    assign o_q_sh    = w_head.sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pads.pad_x <= PAD_X_RESET;
            r_pads.pad_y <= PAD_Y_RESET;
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_count      <= '0;
            r_open       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PAD_X: r_pads.pad_x <= i_cfg_data[PAD_BITS-1:0];
                    REG_PAD_Y: r_pads.pad_y <= i_cfg_data[PAD_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_wptr <= (r_wptr == QPTR'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
                // a frame closes on its last box or on an empty-frame marker
                r_open <= !(i_command || i_last_in_frame);
            end
            if (i_q_pop) begin
                r_rptr <= (r_rptr == QPTR'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT'(w_accept) - QCNT'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wptr] <= w_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== rtl/itr_back.sv =====
// ----------------------------------------------------------------------------
// itr_back
// Carries out queued transactions: frame bookkeeping, padded overlap test
// against the last known box through one shared multiplier, running best
// choice and the frame-end result register.
// ----------------------------------------------------------------------------
module itr_back
    import itr_pkg::*;
#(
    parameter int PIXEL_BITS = 12,
    parameter int ID_BITS    = 16,
    parameter int SW_BITS    = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pads                 i_pads,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  t_item_ctl             i_q_ctl,
    input  logic [ID_BITS-1:0]    i_q_id,
    input  logic [PIXEL_BITS-1:0] i_q_cx,
    input  logic [PIXEL_BITS-1:0] i_q_cy,
    input  logic [PIXEL_BITS-1:0] i_q_w,
    input  logic [PIXEL_BITS-1:0] i_q_h,
    input  logic [SW_BITS-1:0]    i_q_sw,
    input  logic [SW_BITS-1:0]    i_q_sh,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_out_outcome,
    output logic [PIXEL_BITS-1:0] o_out_target_x,
    output logic [PIXEL_BITS-1:0] o_out_target_y,
    output logic [PIXEL_BITS-1:0] o_out_target_h,
    output logic [ID_BITS-1:0]    o_out_tracked_id,
    output logic [MISS_BITS-1:0]  o_out_miss_frames,
    output logic                  o_out_target_present
);

    localparam int E_BITS    = SW_BITS + 2;        // signed doubled edge
    localparam int IW_BITS   = SW_BITS + 1;        // clamped overlap span
    localparam int HB        = SW_BITS + 2;        // multiplier narrow operand
    localparam int UB        = 2 * SW_BITS + 3;    // 4x area / union
    localparam int AREA_BITS = 2 * SW_BITS + 1;    // sum of two padded areas
    localparam int PB        = UB + HB;
    localparam int XB        = 2 * UB;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_HEAD = 4'd1;
    localparam logic [3:0] ST_OVL  = 4'd2;
    localparam logic [3:0] ST_M1   = 4'd3;
    localparam logic [3:0] ST_M2   = 4'd4;
    localparam logic [3:0] ST_M3   = 4'd5;
    localparam logic [3:0] ST_Q    = 4'd6;
    localparam logic [3:0] ST_X1   = 4'd7;
    localparam logic [3:0] ST_X2   = 4'd8;
    localparam logic [3:0] ST_X3   = 4'd9;
    localparam logic [3:0] ST_X4   = 4'd10;
    localparam logic [3:0] ST_DEC  = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] cx;
        logic [PIXEL_BITS-1:0] cy;
        logic [PIXEL_BITS-1:0] w;
        logic [PIXEL_BITS-1:0] h;
    } t_box;

    logic [3:0]               r_state;
    logic [3:0]               n_state;

    t_item_ctl                r_cur_ctl;
    logic [ID_BITS-1:0]       r_cur_id;
    t_box                     r_cur;
    logic [SW_BITS-1:0]       r_cur_sw;
    logic [SW_BITS-1:0]       r_cur_sh;

    logic [ID_BITS-1:0]       r_track_id;
    logic                     r_track_known;
    t_box                     r_ref;
    logic [MISS_BITS-1:0]     r_miss;

    logic                     r_match_found;
    t_box                     r_match_box;
    logic                     r_best_found;
    logic [UB-1:0]            r_best_ov;
    logic [UB-1:0]            r_best_un;
    t_box                     r_best_box;
    logic [ID_BITS-1:0]       r_best_id;
    t_box                     r_first_box;
    logic [ID_BITS-1:0]       r_first_id;

    logic signed [E_BITS-1:0] r_clx, r_chx, r_cly, r_chy;
    logic signed [E_BITS-1:0] r_rlx, r_rhx, r_rly, r_rhy;
    logic [SW_BITS-1:0]       r_ref_sw;
    logic [SW_BITS-1:0]       r_ref_sh;
    logic [IW_BITS-1:0]       r_iw;
    logic [IW_BITS-1:0]       r_ih;
    logic [PB-1:0]            r_prod;
    logic [AREA_BITS-1:0]     r_area;
    logic [UB-1:0]            r_i4;
    logic [UB-1:0]            r_u4;
    logic                     r_qual;
    logic [XB-1:0]            r_x;
    logic [XB-1:0]            r_y;

    logic                     r_out_valid;
    logic [1:0]               r_out_outcome;
    logic [PIXEL_BITS-1:0]    r_out_x;
    logic [PIXEL_BITS-1:0]    r_out_y;
    logic [PIXEL_BITS-1:0]    r_out_h;
    logic [ID_BITS-1:0]       r_out_id;
    logic [MISS_BITS-1:0]     r_out_miss;
    logic                     r_out_has;

    logic [SW_BITS-1:0]       w_ref_sw;
    logic [SW_BITS-1:0]       w_ref_sh;
    logic [ID_BITS-1:0]       w_eff_id;
    logic                     w_id_hit;
    logic signed [E_BITS:0]   w_dx;
    logic signed [E_BITS:0]   w_dy;
    logic [UB-1:0]            w_mul_a;
    logic [HB-1:0]            w_mul_b;
    logic [PB-1:0]            w_prod;
    logic                     w_take;
    logic                     w_out_free;
    logic                     w_use_match;
    logic                     w_use_best;
    logic [UB+2:0]            w_i4x10;

    function automatic logic signed [E_BITS-1:0] f_edge(
        input logic [PIXEL_BITS-1:0] c,
        input logic [SW_BITS-1:0]    s,
        input logic                  up
    );
        logic signed [E_BITS-1:0] c2;
        logic signed [E_BITS-1:0] se;
        c2 = $signed({{(E_BITS-PIXEL_BITS-1){1'b0}}, c, 1'b0});
        se = $signed({2'b00, s});
        return up ? (c2 + se) : (c2 - se);
    endfunction

    function automatic logic signed [E_BITS-1:0] f_min(
        input logic signed [E_BITS-1:0] a,
        input logic signed [E_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [E_BITS-1:0] f_max(
        input logic signed [E_BITS-1:0] a,
        input logic signed [E_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_ref_sw = SW_BITS'(r_ref.w) + SW_BITS'(i_pads.pad_x);
    assign w_ref_sh = SW_BITS'(r_ref.h) + SW_BITS'(i_pads.pad_y);

    // before a track exists the first box of the frame stands in for it
    assign w_eff_id = r_track_known    ? r_track_id :
                      r_cur_ctl.first  ? r_cur_id   : r_first_id;
    assign w_id_hit = !r_match_found && (r_cur_id == w_eff_id);

    always_comb begin
        logic signed [E_BITS-1:0] hx, lx, hy, ly;
        hx   = f_min(r_chx, r_rhx);
        lx   = f_max(r_clx, r_rlx);
        hy   = f_min(r_chy, r_rhy);
        ly   = f_max(r_cly, r_rly);
        w_dx = {hx[E_BITS-1], hx} - {lx[E_BITS-1], lx};
        w_dy = {hy[E_BITS-1], hy} - {ly[E_BITS-1], ly};
    end

    // shared multiplier: areas, intersection, then cross products in halves
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_OVL: begin
                w_mul_a = UB'(r_cur_sw);
                w_mul_b = HB'(r_cur_sh);
            end
            ST_M1: begin
                w_mul_a = UB'(r_ref_sw);
                w_mul_b = HB'(r_ref_sh);
            end
            ST_M2: begin
                w_mul_a = UB'(r_iw);
                w_mul_b = HB'(r_ih);
            end
            ST_Q: begin
                w_mul_a = r_i4;
                w_mul_b = r_best_un[HB-1:0];
            end
            ST_X1: begin
                w_mul_a = r_i4;
                w_mul_b = HB'(r_best_un[UB-1:HB]);
            end
            ST_X2: begin
                w_mul_a = r_best_ov;
                w_mul_b = r_u4[HB-1:0];
            end
            ST_X3: begin
                w_mul_a = r_best_ov;
                w_mul_b = HB'(r_u4[UB-1:HB]);
            end
            default: ;
        endcase
    end

    assign w_prod  = PB'(w_mul_a) * PB'(w_mul_b);
    assign w_i4x10 = {r_i4, 3'b000} + {2'b00, r_i4, 1'b0};
    assign w_take  = r_qual && (!r_best_found || (r_x > r_y));

    assign w_use_match = r_match_found;
    assign w_use_best  = r_track_known && r_best_found;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_HEAD;
            ST_HEAD: begin
                if (r_cur_ctl.cmd) begin
                    n_state = ST_FIN;
                end else if (r_track_known) begin
                    n_state = ST_OVL;
                end else if (r_cur_ctl.last) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OVL:  n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_Q;
            ST_Q:    n_state = ST_X1;
            ST_X1:   n_state = ST_X2;
            ST_X2:   n_state = ST_X3;
            ST_X3:   n_state = ST_X4;
            ST_X4:   n_state = ST_DEC;
            ST_DEC:  n_state = r_cur_ctl.last ? ST_FIN : ST_IDLE;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_track_id    <= '0;
            r_track_known <= 1'b0;
            r_miss        <= '0;
            r_match_found <= 1'b0;
            r_best_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            // a frame end may reload the result in the cycle the old one leaves
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_HEAD && !r_cur_ctl.cmd && w_id_hit) begin
                r_match_found <= 1'b1;
            end
            if (r_state == ST_DEC && w_take) begin
                r_best_found <= 1'b1;
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_match_found <= 1'b0;
                r_best_found  <= 1'b0;
                if (r_cur_ctl.cmd) begin
                    if (r_miss != MISS_MAX) r_miss <= r_miss + 1'b1;
                end else begin
                    r_miss        <= '0;
                    r_track_known <= 1'b1;
                    if (w_use_match) begin
                        r_track_id <= w_eff_id;
                    end else if (w_use_best) begin
                        r_track_id <= r_best_id;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_cur_ctl <= i_q_ctl;
                    r_cur_id  <= i_q_id;
                    r_cur.cx  <= i_q_cx;
                    r_cur.cy  <= i_q_cy;
                    r_cur.w   <= i_q_w;
                    r_cur.h   <= i_q_h;
                    r_cur_sw  <= i_q_sw;
                    r_cur_sh  <= i_q_sh;
                end
            end
            ST_HEAD: begin
                r_clx    <= f_edge(r_cur.cx, r_cur_sw, 1'b0);
                r_chx    <= f_edge(r_cur.cx, r_cur_sw, 1'b1);
                r_cly    <= f_edge(r_cur.cy, r_cur_sh, 1'b0);
                r_chy    <= f_edge(r_cur.cy, r_cur_sh, 1'b1);
                r_rlx    <= f_edge(r_ref.cx, w_ref_sw, 1'b0);
                r_rhx    <= f_edge(r_ref.cx, w_ref_sw, 1'b1);
                r_rly    <= f_edge(r_ref.cy, w_ref_sh, 1'b0);
                r_rhy    <= f_edge(r_ref.cy, w_ref_sh, 1'b1);
                r_ref_sw <= w_ref_sw;
                r_ref_sh <= w_ref_sh;
                if (!r_cur_ctl.cmd) begin
                    if (w_id_hit) r_match_box <= r_cur;
                    if (r_cur_ctl.first) begin
                        r_first_box <= r_cur;
                        r_first_id  <= r_cur_id;
                    end
                end
            end
            ST_OVL: begin
                // clamp: no overlap on either axis gives a zero product
                r_iw <= (!w_dx[E_BITS] && (w_dx != '0)) ? w_dx[IW_BITS-1:0] : '0;
                r_ih <= (!w_dy[E_BITS] && (w_dy != '0)) ? w_dy[IW_BITS-1:0] : '0;
            end
            ST_M1: r_area <= r_prod[AREA_BITS-1:0];
            ST_M2: r_area <= r_area + r_prod[AREA_BITS-1:0];
            ST_M3: begin
                r_i4 <= r_prod[UB-1:0];
                r_u4 <= {r_area, 2'b00} - r_prod[UB-1:0];
            end
            ST_Q:  r_qual <= (w_i4x10 > {3'b000, r_u4});
            ST_X1: r_x <= XB'(r_prod);
            ST_X2: r_x <= r_x + (XB'(r_prod) << HB);
            ST_X3: r_y <= XB'(r_prod);
            ST_X4: r_y <= r_y + (XB'(r_prod) << HB);
            ST_DEC: begin
                if (w_take) begin
                    r_best_ov  <= r_i4;
                    r_best_un  <= r_u4;
                    r_best_box <= r_cur;
                    r_best_id  <= r_cur_id;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    if (r_cur_ctl.cmd) begin
                        r_out_outcome <= OUT_NONE;
                        r_out_x       <= '0;
                        r_out_y       <= '0;
                        r_out_h       <= '0;
                        r_out_id      <= r_track_id;
                        r_out_miss    <= (r_miss != MISS_MAX) ? r_miss + 1'b1 : r_miss;
                        r_out_has     <= 1'b0;
                    end else begin
                        r_out_miss <= '0;
                        r_out_has  <= 1'b1;
                        if (w_use_match) begin
                            r_out_outcome <= OUT_ID_MATCH;
                            r_out_x       <= r_match_box.cx;
                            r_out_y       <= r_match_box.cy;
                            r_out_h       <= r_match_box.h;
                            r_out_id      <= w_eff_id;
                            r_ref         <= r_match_box;
                        end else if (w_use_best) begin
                            r_out_outcome <= OUT_IOU;
                            r_out_x       <= r_best_box.cx;
                            r_out_y       <= r_best_box.cy;
                            r_out_h       <= r_best_box.h;
                            r_out_id      <= r_best_id;
                            r_ref         <= r_best_box;
                        end else begin
                            r_out_outcome <= OUT_FALLBACK;
                            r_out_x       <= r_first_box.cx;
                            r_out_y       <= r_first_box.cy;
                            r_out_h       <= r_first_box.h;
                            r_out_id      <= r_track_id;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_outcome        = r_out_outcome;
    assign o_out_target_x       = r_out_x;
    assign o_out_target_y       = r_out_y;
    assign o_out_target_h       = r_out_h;
    assign o_out_tracked_id     = r_out_id;
    assign o_out_miss_frames    = r_out_miss;
    assign o_out_target_present = r_out_has;

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_outcome == OUT_NONE) |->
            (!r_out_has && r_out_x == '0 && r_out_y == '0 && r_out_h == '0))
        else $error("empty-frame result carries a target");

    a_hit_clears_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has) |-> (r_out_miss == '0))
        else $error("detection result with nonzero miss count");

    a_pop_to_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_HEAD))
        else $error("popped transaction not taken up");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && w_out_free) |=> r_out_valid)
        else $error("frame end did not load the result register");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for iou_target_reacquire_core. Detection frames and
// empty-frame markers are streamed in while a local track model predicts the
// report for every frame end. Each report is compared field by field. The
// bench runs directed cases, a long output stall, then random traffic under
// several pad settings and a run of empty frames.
// ----------------------------------------------------------------------------
module tb_top
    import itr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_BITS    = 12;
    localparam int ID_BITS       = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int MISS_RUN      = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd2;
    localparam logic CMD_BOX   = 1'b0;
    localparam logic CMD_EMPTY = 1'b1;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    typedef struct packed {
        logic                  cmd;
        logic [ID_BITS-1:0]    id;
        logic [PIXEL_BITS-1:0] cx;
        logic [PIXEL_BITS-1:0] cy;
        logic [PIXEL_BITS-1:0] w;
        logic [PIXEL_BITS-1:0] h;
        logic                  last;
    } det_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] cx;
        logic [PIXEL_BITS-1:0] cy;
        logic [PIXEL_BITS-1:0] w;
        logic [PIXEL_BITS-1:0] h;
    } det_box_t;

    typedef struct packed {
        logic [1:0]            outcome;
        logic [PIXEL_BITS-1:0] target_x;
        logic [PIXEL_BITS-1:0] target_y;
        logic [PIXEL_BITS-1:0] target_h;
        logic [ID_BITS-1:0]    tracked_id;
        logic [MISS_BITS-1:0]  miss_frames;
        logic                  target_present;
    } frame_report_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_command;
    logic [ID_BITS-1:0]       i_det_id;
    logic [PIXEL_BITS-1:0]    i_box_cx;
    logic [PIXEL_BITS-1:0]    i_box_cy;
    logic [PIXEL_BITS-1:0]    i_box_w;
    logic [PIXEL_BITS-1:0]    i_box_h;
    logic                     i_last_in_frame;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [1:0]               o_outcome;
    logic [PIXEL_BITS-1:0]    o_target_x;
    logic [PIXEL_BITS-1:0]    o_target_y;
    logic [PIXEL_BITS-1:0]    o_target_h;
    logic [ID_BITS-1:0]       o_tracked_id;
    logic [MISS_BITS-1:0]     o_miss_frames;
    logic                     o_target_present;

    iou_target_reacquire_core #(
        .PIXEL_BITS (PIXEL_BITS),
        .ID_BITS    (ID_BITS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_det_id         (i_det_id),
        .i_box_cx         (i_box_cx),
        .i_box_cy         (i_box_cy),
        .i_box_w          (i_box_w),
        .i_box_h          (i_box_h),
        .i_last_in_frame  (i_last_in_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_target_x       (o_target_x),
        .o_target_y       (o_target_y),
        .o_target_h       (o_target_h),
        .o_tracked_id     (o_tracked_id),
        .o_miss_frames    (o_miss_frames),
        .o_target_present (o_target_present)
    );

    // Track model state
    logic [PAD_BITS-1:0]  pad_x_q, pad_y_q;
    logic [ID_BITS-1:0]   trk_id;
    bit                   trk_known;
    det_box_t             ref_bx;
    logic [MISS_BITS-1:0] miss_cnt;
    bit                   m_found;
    det_box_t             m_box;
    bit                   b_found;
    longint unsigned      b_ovl, b_uni;
    det_box_t             b_box;
    logic [ID_BITS-1:0]   b_id;
    det_box_t             f_box;
    logic [ID_BITS-1:0]   f_id;
    bit                   f_open;

    frame_report_t frame_reports_due[$];
    det_item_t     last_box_sent;
    int            err_count   = 0;
    bit            idle_on     = 1'b1;
    int            hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("** iou_target_reacquire_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Track model
    // ------------------------------------------------------------------------
    function automatic void drop_frame();
        m_found = 1'b0;
        m_box   = '0;
        b_found = 1'b0;
        b_ovl   = 0;
        b_uni   = 0;
        b_box   = '0;
        b_id    = '0;
        f_box   = '0;
        f_id    = '0;
        f_open  = 1'b0;
    endfunction

    function automatic void reset_track_model();
        pad_x_q   = PAD_X_RESET;
        pad_y_q   = PAD_Y_RESET;
        trk_id    = '0;
        trk_known = 1'b0;
        ref_bx    = '0;
        miss_cnt  = '0;
        drop_frame();
    endfunction

    // Overlap along one axis in doubled pixel units; negative when apart
    function automatic longint axis_overlap(longint c1, longint s1, longint c2, longint s2);
        longint hi, lo;
        hi = (2 * c1 + s1 < 2 * c2 + s2) ? 2 * c1 + s1 : 2 * c2 + s2;
        lo = (2 * c1 - s1 > 2 * c2 - s2) ? 2 * c1 - s1 : 2 * c2 - s2;
        return hi - lo;
    endfunction

    function automatic void padded_iou(input det_box_t a, input det_box_t b,
                                       output longint unsigned i4,
                                       output longint unsigned u4);
        longint aw, ah, bw, bh, iw, ih;
        aw = longint'(a.w) + longint'(pad_x_q);
        ah = longint'(a.h) + longint'(pad_y_q);
        bw = longint'(b.w) + longint'(pad_x_q);
        bh = longint'(b.h) + longint'(pad_y_q);
        iw = axis_overlap(a.cx, aw, b.cx, bw);
        ih = axis_overlap(a.cy, ah, b.cy, bh);
        i4 = (iw > 0 && ih > 0) ? iw * ih : 0;
        u4 = 4 * aw * ah + 4 * bw * bh - i4;
    endfunction

    // Absorb one transaction; returns 1 with the frame report at a frame end
    function automatic bit track_frame_step(input det_item_t it, output frame_report_t rep);
        det_box_t           bx, pick;
        logic [ID_BITS-1:0] eff_id;
        longint unsigned    i4, u4;
        rep = '0;
        if (it.cmd == CMD_EMPTY) begin
            drop_frame();
            if (miss_cnt != MISS_MAX) miss_cnt++;
            rep.outcome     = OUT_NONE;
            rep.tracked_id  = trk_id;
            rep.miss_frames = miss_cnt;
            return 1'b1;
        end
        bx.cx = it.cx;
        bx.cy = it.cy;
        bx.w  = it.w;
        bx.h  = it.h;
        if (!f_open) begin
            f_open = 1'b1;
            f_box  = bx;
            f_id   = it.id;
        end
        eff_id = trk_known ? trk_id : f_id;
        if (!m_found && it.id == eff_id) begin
            m_found = 1'b1;
            m_box   = bx;
        end
        if (trk_known) begin
            padded_iou(bx, ref_bx, i4, u4);
            if (10 * i4 > u4 && (!b_found || i4 * b_uni > b_ovl * u4)) begin
                b_found = 1'b1;
                b_ovl   = i4;
                b_uni   = u4;
                b_box   = bx;
                b_id    = it.id;
            end
        end
        if (!it.last) return 1'b0;

        if (m_found) begin
            rep.outcome = OUT_ID_MATCH;
            pick        = m_box;
            trk_id      = eff_id;
            ref_bx      = m_box;
        end else if (trk_known && b_found) begin
            rep.outcome = OUT_IOU;
            pick        = b_box;
            trk_id      = b_id;
            ref_bx      = b_box;
        end else begin
            rep.outcome = OUT_FALLBACK;
            pick        = f_box;
        end
        trk_known = 1'b1;
        miss_cnt  = '0;
        drop_frame();
        rep.target_x       = pick.cx;
        rep.target_y       = pick.cy;
        rep.target_h       = pick.h;
        rep.tracked_id     = trk_id;
        rep.miss_frames    = '0;
        rep.target_present = 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Report checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            $display("[%0t] %s mismatch: expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        frame_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_reports_due.size() == 0) begin
                err_count++;
                $display("[%0t] report with none expected: expected nothing, actual %0d/%0d",
                         $time, o_outcome, o_tracked_id);
            end else begin
                want = frame_reports_due.pop_front();
                check_field("outcome",        want.outcome,        o_outcome);
                check_field("target_x",       want.target_x,       o_target_x);
                check_field("target_y",       want.target_y,       o_target_y);
                check_field("target_h",       want.target_h,       o_target_h);
                check_field("tracked_id",     want.tracked_id,     o_tracked_id);
                check_field("miss_frames",    want.miss_frames,    o_miss_frames);
                check_field("target_present", want.target_present, o_target_present);
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Report receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (!idle_on) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) stall_left = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic det_item_t box_item(logic [ID_BITS-1:0] id, int cx, int cy,
                                           int w, int h, bit last);
        det_item_t it;
        it.cmd  = CMD_BOX;
        it.id   = id;
        it.cx   = cx[PIXEL_BITS-1:0];
        it.cy   = cy[PIXEL_BITS-1:0];
        it.w    = w[PIXEL_BITS-1:0];
        it.h    = h[PIXEL_BITS-1:0];
        it.last = last;
        return it;
    endfunction

    // Other fields of an empty-frame marker carry junk
    function automatic det_item_t empty_item();
        det_item_t it;
        it     = box_item(ID_BITS'($urandom), $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
        it.cmd = CMD_EMPTY;
        return it;
    endfunction

    function automatic det_item_t near_track_item(logic [ID_BITS-1:0] id, int spread, bit last);
        return box_item(id, ref_bx.cx + jitter(spread), ref_bx.cy + jitter(spread),
                        ref_bx.w + jitter(spread / 4), ref_bx.h + jitter(spread / 4), last);
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return trk_id;
        if (r < 5) return trk_id ^ (ID_BITS'(1) << $urandom_range(0, ID_BITS - 1));
        if (r < 7) return ID_BITS'($urandom_range(0, 7));
        return ID_BITS'($urandom);
    endfunction

    function automatic int extreme_pix();
        return $urandom_range(0, 1) ? int'(PIX_MAX) : 0;
    endfunction

    function automatic det_item_t random_box_item(bit last);
        det_item_t it;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            it = near_track_item(pick_id(), ($urandom_range(0, 3) == 0) ? 300 : 20, last);
        end else if (sel < 55) begin
            // repeat the previous box to provoke overlap ties
            it      = last_box_sent;
            it.cmd  = CMD_BOX;
            it.id   = pick_id();
            it.last = last;
        end else if (sel < 88) begin
            it = box_item(pick_id(), $urandom, $urandom, $urandom, $urandom, last);
        end else begin
            it = box_item(pick_id(), extreme_pix(), extreme_pix(), extreme_pix(),
                          extreme_pix(), last);
        end
        return it;
    endfunction

    // Offer one transaction; returns at a falling edge, valid still high on a zero gap
    task automatic send_item(input det_item_t it);
        frame_report_t rep;
        int            gap;
        i_in_valid      <= 1'b1;
        i_command       <= it.cmd;
        i_det_id        <= it.id;
        i_box_cx        <= it.cx;
        i_box_cy        <= it.cy;
        i_box_w         <= it.w;
        i_box_h         <= it.h;
        i_last_in_frame <= it.last;
        do @(posedge i_clk); while (!o_in_ready);
        if (track_frame_step(it, rep)) frame_reports_due.push_back(rep);
        if (it.cmd == CMD_BOX) last_box_sent = it;
        @(negedge i_clk);
        gap = idle_on ? gap_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid, drain all reports, then let the core finish absorbed boxes
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (frame_reports_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_PAD_X) pad_x_q = data[PAD_BITS-1:0];
        else if (idx == REG_PAD_Y) pad_y_q = data[PAD_BITS-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_unseeded_frames();
        send_item(empty_item());
        // partial frame then empty marker: the pending seed must be lost
        send_item(box_item(16'h1234, 900, 900, 30, 30, 1'b0));
        send_item(empty_item());
        send_item(box_item(16'hAAAA, 500, 400, 60, 80, 1'b0));
        send_item(box_item(16'h5555, 2000, 2000, 90, 90, 1'b0));
        send_item(box_item(16'hAAAA, 510, 410, 60, 80, 1'b1));
        wait_idle();
    endtask

    task automatic test_id_match();
        send_item(near_track_item(16'h0001, 10, 1'b0));
        send_item(box_item(trk_id, 700, 600, 40, 50, 1'b0));
        send_item(box_item(trk_id, 1500, 1500, 40, 50, 1'b1));
        wait_idle();
    endtask

    task automatic test_iou_reacquire();
        send_item(box_item(16'h0100, 3000, 3000, 40, 50, 1'b0));
        send_item(box_item(16'h0200, ref_bx.cx + 30, ref_bx.cy + 30, 40, 50, 1'b0));
        // two identical best boxes: the earlier one wins
        send_item(box_item(16'h0300, ref_bx.cx, ref_bx.cy, ref_bx.w, ref_bx.h, 1'b0));
        send_item(box_item(16'h0400, ref_bx.cx, ref_bx.cy, ref_bx.w, ref_bx.h, 1'b1));
        wait_idle();
    endtask

    task automatic test_fallback();
        send_item(box_item(16'h0F0F, 100, 3900, 10, 10, 1'b0));
        send_item(box_item(16'hF0F0, 3900, 100, 10, 10, 1'b1));
        wait_idle();
    endtask

    task automatic test_pad_mid_frame();
        send_item(near_track_item(16'h0BAD, 300, 1'b0));
        send_item(near_track_item(16'h0BAE, 300, 1'b0));
        wait_idle();
        // upper data bits must be dropped
        write_reg(REG_PAD_X, 16'hFC00);
        write_reg(REG_PAD_Y, 16'h03FF);
        write_reg(REG_SPARE, 16'hFFFF);
        send_item(near_track_item(16'h0BAF, 300, 1'b1));
        wait_idle();
        write_reg(REG_PAD_X, {6'h2A, PAD_X_RESET});
        write_reg(REG_PAD_Y, {6'h15, PAD_Y_RESET});
    endtask

    task automatic test_field_extremes();
        send_item(box_item(16'hFFFF, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, 1'b1));
        send_item(box_item(16'h0000, 0, 0, 0, 0, 1'b0));
        send_item(box_item(16'hFFFF, 0, PIX_MAX, 0, PIX_MAX, 1'b1));
        wait_idle();
    endtask

    task automatic random_frame(inout int sent);
        int kind, n;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_item(empty_item());
            sent++;
        end else if (kind < 20) begin
            // broken frame cut short by an empty marker
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_item(random_box_item(1'b0));
                sent++;
            end
            send_item(empty_item());
            sent++;
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
            for (int k = 1; k <= n; k++) begin
                send_item(random_box_item(k == n));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int sent, frames;
        sent   = 0;
        frames = 0;
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(REG_PAD_X, 16'h0000);
                    write_reg(REG_PAD_Y, 16'h0000);
                end
                1: begin
                    write_reg(REG_PAD_X, 16'hFFFF);
                    write_reg(REG_PAD_Y, 16'hFFFF);
                end
                2: begin
                    write_reg(REG_PAD_X, CFG_DATA_BITS'($urandom));
                    write_reg(REG_PAD_Y, CFG_DATA_BITS'($urandom));
                end
                3: begin
                    write_reg(REG_PAD_X, 16'h0000);
                    write_reg(REG_PAD_Y, 16'h03FF);
                end
                default: begin
                    write_reg(REG_PAD_X, PAD_X_RESET);
                    write_reg(REG_PAD_Y, PAD_Y_RESET);
                end
            endcase
            while (sent < (ph + 1) * RANDOM_ITEMS / 5) begin
                if (frames % 16 == 0) idle_on = ($urandom_range(0, 4) != 0);
                frames++;
                if ($urandom_range(0, 39) == 0) wait_idle();
                random_frame(sent);
            end
        end
        idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_output_stall();
        idle_on     = 1'b0;
        hold_cycles = 400;
        for (int k = 0; k < 16; k++)
            send_item((k % 4 == 3) ? empty_item() : near_track_item(pick_id(), 20, 1'b1));
        idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_miss_run();
        idle_on = 1'b0;
        repeat (MISS_RUN) send_item(empty_item());
        // a detection clears the count
        send_item(near_track_item(trk_id, 0, 1'b1));
        idle_on = 1'b1;
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_PAD_X;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_command       = CMD_BOX;
        i_det_id        = '0;
        i_box_cx        = '0;
        i_box_cy        = '0;
        i_box_w         = '0;
        i_box_h         = '0;
        i_last_in_frame = 1'b0;
        last_box_sent   = '0;
        reset_track_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unseeded_frames();
        test_id_match();
        test_iou_reacquire();
        test_fallback();
        test_pad_mid_frame();
        test_field_extremes();
        test_output_stall();
        test_random_traffic();
        test_miss_run();
        wait_idle();

        if (err_count == 0 && frame_reports_due.size() == 0) begin
            $display("** iou_target_reacquire_core: PASSED **");
        end else begin
            $display("** iou_target_reacquire_core: FAILED **");
        end
        $finish;
    end

endmodule
